>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

>>> hw/rtl/frd_pkg.sv
// ----------------------------------------------------------------------------
// Frame difference package
// Widths, reset values, register indexes and helpers of the dirty
// rectangle detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frd_pkg;

  localparam int unsigned MAX_DIM         = 4096;
  localparam int unsigned DIM_W           = 13;
  localparam int unsigned COORD_W         = 12;
  localparam int unsigned PIX_W           = 8;
  localparam int unsigned STRIP_IDX_W     = 4;
  localparam int unsigned STRIP_COUNT_DEF = 10;
  localparam int unsigned STRIP_MIN_WIDTH = 200;
  localparam int unsigned CFG_DATA_W      = 13;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned RST_WIDTH       = 1920;
  localparam int unsigned RST_HEIGHT      = 1080;
  localparam logic        RST_MODE        = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_STRIP_MODE   = 2'd2
  } cfg_reg_t;

  // Clamps a dimension to 1..MAX_DIM and returns the index of its last element.
  function automatic logic [COORD_W-1:0] clamp_last(input logic [CFG_DATA_W-1:0] v);
    logic [CFG_DATA_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > CFG_DATA_W'(MAX_DIM)) begin
      r = CFG_DATA_W'(MAX_DIM - 1);
    end else begin
      r = v - 1'b1;
    end
    return r[COORD_W-1:0];
  endfunction

endpackage

>>> hw/rtl/frame_diff_dirty_rect_core.sv
// ----------------------------------------------------------------------------
// Frame difference dirty rectangle core
// Tracks per-strip bounding boxes of changed pixels over a raster frame and
// reports one rectangle per strip after the frame's last pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The core takes one current/previous pixel pair per clock in raster order
// and keeps its own column and line position. Each pixel updates only the
// box of the strip it falls in, so a pixel is accepted every cycle. When the
// last pixel of a frame is accepted, all strip boxes are copied into a result
// bank and cleared for the next frame, and the bank then delivers one result
// per clock unless stalled (one, or STRIP_COUNT in strip mode when the width
// is at least 200), the final one marked by last. The next frame streams in
// meanwhile; only its own last pixel is held off while the bank still has
// results left to deliver. A configuration write restarts the frame, drops
// the partial frame's boxes and holds off the pixel input in its own cycle.
`include "assert_macros.svh"

module frame_diff_dirty_rect_core #(
  parameter int unsigned STRIP_COUNT = frd_pkg::STRIP_COUNT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [frd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [frd_pkg::CFG_DATA_W-1:0]    cfg_data,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [frd_pkg::PIX_W-1:0]         cur_red,
  input  logic [frd_pkg::PIX_W-1:0]         cur_green,
  input  logic [frd_pkg::PIX_W-1:0]         cur_blue,
  input  logic [frd_pkg::PIX_W-1:0]         prev_red,
  input  logic [frd_pkg::PIX_W-1:0]         prev_green,
  input  logic [frd_pkg::PIX_W-1:0]         prev_blue,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [frd_pkg::STRIP_IDX_W-1:0]   strip_index,
  output logic                              changed,
  output logic [frd_pkg::COORD_W-1:0]       rect_x,
  output logic [frd_pkg::COORD_W-1:0]       rect_y,
  output logic [frd_pkg::DIM_W-1:0]         rect_width,
  output logic [frd_pkg::DIM_W-1:0]         rect_height,
  output logic                              last
);

  import frd_pkg::*;

  localparam int unsigned SIDX_W   = (STRIP_COUNT > 1) ? $clog2(STRIP_COUNT) : 1;
  localparam int unsigned CNT_W    = $clog2(STRIP_COUNT + 1);
  localparam int unsigned RECIP_SH = DIM_W + $clog2(STRIP_COUNT);
  localparam int unsigned RECIP    = ((2 ** RECIP_SH) + STRIP_COUNT - 1) / STRIP_COUNT;
  localparam int unsigned RECIP_W  = DIM_W + 2;
  localparam int unsigned PROD_W   = DIM_W + RECIP_W;
  localparam int unsigned RST_N    = (RST_WIDTH >= STRIP_MIN_WIDTH) ? STRIP_COUNT : 1;
  localparam int unsigned RST_PS   = RST_WIDTH / RST_N;

  // Frame geometry, derived at configuration time.
  logic [COORD_W-1:0] width_last;
  logic [COORD_W-1:0] height_last;
  logic               strip_mode;
  logic [CNT_W-1:0]   strips;
  logic [DIM_W-1:0]   strip_size;

  logic [COORD_W-1:0] cand_wlast;
  logic [COORD_W-1:0] cand_hlast;
  logic               cand_mode;
  logic [DIM_W-1:0]   cand_w;
  logic               cand_split;
  logic [PROD_W-1:0]  cand_prod;
  logic [CNT_W-1:0]   cand_n;
  logic [DIM_W-1:0]   cand_ps;
  logic               cfg_write;
  logic               cfg_known;

  // Position and strip boxes.
  logic [COORD_W-1:0] col_count;
  logic [COORD_W-1:0] line_count;
  logic [SIDX_W-1:0]  strip_now;
  logic [COORD_W-1:0] strip_col;
  logic [COORD_W-1:0] box_min_x [STRIP_COUNT];
  logic [COORD_W-1:0] box_max_x [STRIP_COUNT];
  logic [COORD_W-1:0] box_min_y [STRIP_COUNT];
  logic [COORD_W-1:0] box_max_y [STRIP_COUNT];
  logic [STRIP_COUNT-1:0] box_hit;

  // Result bank.
  logic [COORD_W-1:0] snap_min_x [STRIP_COUNT];
  logic [COORD_W-1:0] snap_max_x [STRIP_COUNT];
  logic [COORD_W-1:0] snap_min_y [STRIP_COUNT];
  logic [COORD_W-1:0] snap_max_y [STRIP_COUNT];
  logic [STRIP_COUNT-1:0] snap_hit;
  logic [CNT_W-1:0]   snap_n;
  logic [SIDX_W-1:0]  drain_idx;
  logic               busy;

  logic               pix_accept;
  logic               at_line_end;
  logic               at_frame_end;
  logic               drain_fire;
  logic               drain_done;
  logic               diff;
  logic [SIDX_W-1:0]  sel;
  logic [COORD_W-1:0] sel_scol;
  logic               sel_hit;
  logic [COORD_W-1:0] new_min_x;
  logic [COORD_W-1:0] new_max_x;
  logic [COORD_W-1:0] new_min_y;
  logic [COORD_W-1:0] new_max_y;
  logic               strip_advance;

  always_comb begin
    cfg_known = (cfg_index == CFG_FRAME_WIDTH) || (cfg_index == CFG_FRAME_HEIGHT) ||
                (cfg_index == CFG_STRIP_MODE);
    cfg_write = cfg_valid && cfg_ready && cfg_known;
    cand_wlast = width_last;
    cand_hlast = height_last;
    cand_mode  = strip_mode;
    case (cfg_index)
      CFG_FRAME_WIDTH:  cand_wlast = clamp_last(cfg_data);
      CFG_FRAME_HEIGHT: cand_hlast = clamp_last(cfg_data);
      CFG_STRIP_MODE:   cand_mode  = cfg_data[0];
      default:          cand_mode  = strip_mode;
    endcase
    cand_w     = {1'b0, cand_wlast} + DIM_W'(1);
    cand_split = cand_mode && (cand_w >= DIM_W'(STRIP_MIN_WIDTH));
    cand_prod  = PROD_W'(cand_w) * PROD_W'(RECIP);
    cand_n     = cand_split ? CNT_W'(STRIP_COUNT) : CNT_W'(1);
    cand_ps    = cand_split ? DIM_W'(cand_prod >> RECIP_SH) : cand_w;
  end

  assign cfg_ready = 1'b1;

  always_comb begin
    at_line_end  = (col_count == width_last);
    at_frame_end = at_line_end && (line_count == height_last);
    drain_fire   = busy && (!out_valid || !out_stall);
    drain_done   = drain_fire && (CNT_W'(drain_idx) + CNT_W'(1) == snap_n);
    in_stall     = (at_frame_end && busy && !drain_done) || cfg_write;
    pix_accept   = in_valid && !in_stall && !cfg_write;

    diff = (cur_red != prev_red) || (cur_green != prev_green) || (cur_blue != prev_blue);

    if (col_count == '0) begin
      sel      = (strip_size == '0) ? SIDX_W'(strips - CNT_W'(1)) : '0;
      sel_scol = '0;
    end else begin
      sel      = strip_now;
      sel_scol = strip_col;
    end

    sel_hit   = box_hit[sel];
    new_min_x = (!sel_hit || col_count < box_min_x[sel]) ? col_count : box_min_x[sel];
    new_max_x = (!sel_hit || col_count > box_max_x[sel]) ? col_count : box_max_x[sel];
    new_min_y = (!sel_hit || line_count < box_min_y[sel]) ? line_count : box_min_y[sel];
    new_max_y = (!sel_hit || line_count > box_max_y[sel]) ? line_count : box_max_y[sel];

    strip_advance = (strip_size != '0) &&
                    ({1'b0, sel_scol} + DIM_W'(1) >= strip_size) &&
                    (CNT_W'(sel) + CNT_W'(1) < strips);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_last  <= COORD_W'(RST_WIDTH - 1);
      height_last <= COORD_W'(RST_HEIGHT - 1);
      strip_mode  <= RST_MODE;
      strips      <= CNT_W'(RST_N);
      strip_size  <= DIM_W'(RST_PS);
      col_count   <= '0;
      line_count  <= '0;
      strip_now   <= '0;
      strip_col   <= '0;
      box_hit     <= '0;
    end else if (cfg_write) begin
      width_last  <= cand_wlast;
      height_last <= cand_hlast;
      strip_mode  <= cand_mode;
      strips      <= cand_n;
      strip_size  <= cand_ps;
      col_count   <= '0;
      line_count  <= '0;
      strip_now   <= '0;
      strip_col   <= '0;
      box_hit     <= '0;
    end else if (pix_accept) begin
      if (diff && !at_frame_end) begin
        box_hit[sel] <= 1'b1;
      end
      if (at_frame_end) begin
        box_hit    <= '0;
        col_count  <= '0;
        line_count <= '0;
        strip_now  <= '0;
        strip_col  <= '0;
      end else if (at_line_end) begin
        col_count  <= '0;
        line_count <= line_count + 1'b1;
        strip_now  <= sel;
        strip_col  <= sel_scol;
      end else begin
        col_count <= col_count + 1'b1;
        if (strip_advance) begin
          strip_now <= sel + 1'b1;
          strip_col <= '0;
        end else begin
          strip_now <= sel;
          strip_col <= sel_scol + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_accept && diff) begin
      box_min_x[sel] <= new_min_x;
      box_max_x[sel] <= new_max_x;
      box_min_y[sel] <= new_min_y;
      box_max_y[sel] <= new_max_y;
    end
    if (pix_accept && at_frame_end) begin
      for (int k = 0; k < STRIP_COUNT; k++) begin
        if (diff && sel == SIDX_W'(k)) begin
          snap_min_x[k] <= new_min_x;
          snap_max_x[k] <= new_max_x;
          snap_min_y[k] <= new_min_y;
          snap_max_y[k] <= new_max_y;
          snap_hit[k]   <= 1'b1;
        end else begin
          snap_min_x[k] <= box_min_x[k];
          snap_max_x[k] <= box_max_x[k];
          snap_min_y[k] <= box_min_y[k];
          snap_max_y[k] <= box_max_y[k];
          snap_hit[k]   <= box_hit[k];
        end
      end
      snap_n <= strips;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      drain_idx <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pix_accept && at_frame_end) begin
        busy      <= 1'b1;
        drain_idx <= '0;
      end else if (drain_done) begin
        busy      <= 1'b0;
        drain_idx <= '0;
      end else if (drain_fire) begin
        drain_idx <= drain_idx + 1'b1;
      end
      if (drain_fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (drain_fire) begin
      strip_index <= STRIP_IDX_W'(drain_idx);
      last        <= (CNT_W'(drain_idx) + CNT_W'(1) == snap_n);
      if (snap_hit[drain_idx]) begin
        changed     <= 1'b1;
        rect_x      <= snap_min_x[drain_idx];
        rect_y      <= snap_min_y[drain_idx];
        rect_width  <= {1'b0, snap_max_x[drain_idx]} - {1'b0, snap_min_x[drain_idx]} +
                       DIM_W'(1);
        rect_height <= {1'b0, snap_max_y[drain_idx]} - {1'b0, snap_min_y[drain_idx]} +
                       DIM_W'(1);
      end else begin
        changed     <= 1'b0;
        rect_x      <= '0;
        rect_y      <= '0;
        rect_width  <= '0;
        rect_height <= '0;
      end
    end
  end

  `ASSERT_NEVER(a_bank_empty, clk, rst, busy && snap_n == '0)
  `ASSERT_PROP(a_frame_end_loads_bank, clk, rst, (pix_accept && at_frame_end) |=> busy)
  `ASSERT_NEVER(a_strip_range, clk, rst, CNT_W'(strip_now) >= strips)
  `ASSERT_PROP(a_col_step, clk, rst,
    (pix_accept && !at_line_end) |=> (col_count == $past(col_count) + 1'b1))

endmodule

>>> test/tb_frame_diff_dirty_rect_core.sv
// ----------------------------------------------------------------------------
// Dirty rectangle core testbench
// Streams pixel pairs through the core under several frame sizes and strip
// modes, predicts every strip rectangle in step with the accepted pixels,
// and compares each delivered rectangle with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_frame_diff_dirty_rect_core;
  import frd_pkg::*;

  localparam int STRIPS = STRIP_COUNT_DEF;

  typedef struct packed {
    logic [PIX_W-1:0] cr, cg, cb, pr, pg, pb;
  } pixel_t;

  typedef struct packed {
    logic [STRIP_IDX_W-1:0] idx;
    logic                   chg;
    logic [COORD_W-1:0]     x, y;
    logic [DIM_W-1:0]       wd, ht;
    logic                   fin;
  } rect_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  pixel_t                 drv_pix = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STRIP_IDX_W-1:0] strip_index;
  logic                   changed;
  logic [COORD_W-1:0]     rect_x, rect_y;
  logic [DIM_W-1:0]       rect_width, rect_height;
  logic                   last;

  pixel_t pix_q[$];
  rect_t  rect_q[$];
  int     err_count = 0;
  int     snd_idle = 0;
  int     rcv_idle = 0;
  int     done_rand = 0;
  logic   hold_arm = 1'b0;
  int     hold_left = 0;

  logic [DIM_W-1:0]   pred_width = DIM_W'(RST_WIDTH);
  logic [DIM_W-1:0]   pred_height = DIM_W'(RST_HEIGHT);
  logic               pred_mode = RST_MODE;
  logic [COORD_W-1:0] at_col, at_line;
  logic [COORD_W-1:0] lo_x[STRIPS], hi_x[STRIPS], lo_y[STRIPS], hi_y[STRIPS];
  logic               hit[STRIPS];

  frame_diff_dirty_rect_core uut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cur_red(drv_pix.cr),
    .cur_green(drv_pix.cg),
    .cur_blue(drv_pix.cb),
    .prev_red(drv_pix.pr),
    .prev_green(drv_pix.pg),
    .prev_blue(drv_pix.pb),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .strip_index(strip_index),
    .changed(changed),
    .rect_x(rect_x),
    .rect_y(rect_y),
    .rect_width(rect_width),
    .rect_height(rect_height),
    .last(last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [DIM_W-1:0] usable_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return v;
  endfunction

  task automatic restart_frame();
    at_col = '0;
    at_line = '0;
    for (int k = 0; k < STRIPS; k++) begin
      lo_x[k] = '1;
      hi_x[k] = '0;
      lo_y[k] = '1;
      hi_y[k] = '0;
      hit[k] = 1'b0;
    end
  endtask

  task automatic track_pixel(input pixel_t p);
    logic [DIM_W-1:0] w, h;
    int               n, span, s;
    logic             differs;
    rect_t            r;
    w = usable_dim(pred_width);
    h = usable_dim(pred_height);
    n = (pred_mode && w >= DIM_W'(STRIP_MIN_WIDTH)) ? STRIPS : 1;
    span = int'(w) / n;
    s = (span == 0) ? n - 1 : int'(at_col) / span;
    if (s > n - 1) s = n - 1;
    differs = (p.cr != p.pr) || (p.cg != p.pg) || (p.cb != p.pb);
    if (differs) begin
      if (!hit[s] || at_col < lo_x[s]) lo_x[s] = at_col;
      if (!hit[s] || at_col > hi_x[s]) hi_x[s] = at_col;
      if (!hit[s] || at_line < lo_y[s]) lo_y[s] = at_line;
      if (!hit[s] || at_line > hi_y[s]) hi_y[s] = at_line;
      hit[s] = 1'b1;
    end
    if (int'(at_col) + 1 >= int'(w)) begin
      at_col = '0;
      if (int'(at_line) + 1 >= int'(h)) begin
        for (int k = 0; k < n; k++) begin
          r.idx = STRIP_IDX_W'(k);
          r.chg = hit[k];
          r.x = hit[k] ? lo_x[k] : '0;
          r.y = hit[k] ? lo_y[k] : '0;
          r.wd = hit[k] ? {1'b0, hi_x[k]} - {1'b0, lo_x[k]} + DIM_W'(1) : '0;
          r.ht = hit[k] ? {1'b0, hi_y[k]} - {1'b0, lo_y[k]} + DIM_W'(1) : '0;
          r.fin = (k == n - 1);
          rect_q.push_back(r);
        end
        restart_frame();
      end else begin
        at_line = at_line + 1'b1;
      end
    end else begin
      at_col = at_col + 1'b1;
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] seen);
    if (seen !== want) begin
      err_count++;
      $display("%0t: %s expected %0h, actual %0h", $time, name, want, seen);
    end
  endtask

  task automatic check_rect();
    rect_t e;
    if (rect_q.size() == 0) begin
      err_count++;
      $display("%0t: strip_index expected none, actual %0h", $time, strip_index);
    end else begin
      e = rect_q.pop_front();
      check_field("strip_index", 16'(e.idx), 16'(strip_index));
      check_field("changed", 16'(e.chg), 16'(changed));
      check_field("rect_x", 16'(e.x), 16'(rect_x));
      check_field("rect_y", 16'(e.y), 16'(rect_y));
      check_field("rect_width", 16'(e.wd), 16'(rect_width));
      check_field("rect_height", 16'(e.ht), 16'(rect_height));
      check_field("last", 16'(e.fin), 16'(last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_pixel(drv_pix);
      if (!in_valid || !in_stall) begin
        if (pix_q.size() != 0 && $urandom_range(0, 99) >= snd_idle) begin
          drv_pix <= pix_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_rect();
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < rcv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_arm) begin
      hold_left <= 400;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH: pred_width = val;
      CFG_FRAME_HEIGHT: pred_height = val;
      CFG_STRIP_MODE: pred_mode = val[0];
      default: ;
    endcase
    restart_frame();
  endtask

  task automatic set_frame(input int w, input int h, input int m);
    write_reg(CFG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(CFG_STRIP_MODE, CFG_DATA_W'(m));
    @(negedge clk);
  endtask

  function automatic pixel_t rand_pixel(input int rate);
    pixel_t     p;
    logic [2:0] chans;
    p.cr = PIX_W'($urandom);
    p.cg = PIX_W'($urandom);
    p.cb = PIX_W'($urandom);
    p.pr = p.cr;
    p.pg = p.cg;
    p.pb = p.cb;
    if ($urandom_range(0, 999) < rate) begin
      chans = 3'($urandom_range(1, 7));
      if (chans[0]) p.pr = p.cr ^ PIX_W'($urandom_range(1, 255));
      if (chans[1]) p.pg = p.cg ^ PIX_W'($urandom_range(1, 255));
      if (chans[2]) p.pb = p.cb ^ PIX_W'($urandom_range(1, 255));
    end
    return p;
  endfunction

  task automatic push_random(input int count, input int rate);
    for (int i = 0; i < count; i++) pix_q.push_back(rand_pixel(rate));
  endtask

  task automatic drain();
    do @(negedge clk); while (pix_q.size() != 0 || in_valid || rect_q.size() != 0);
    repeat (32) @(negedge clk);
  endtask

  task automatic random_frames(input int target);
    int w_sel, h_sel, m_sel, count, rate;
    while (done_rand < target) begin
      w_sel = $urandom_range(0, 7);
      h_sel = $urandom_range(0, 4);
      m_sel = $urandom_range(0, 1);
      set_frame(w_sel, h_sel, m_sel);
      count = int'(usable_dim(DIM_W'(w_sel))) * int'(usable_dim(DIM_W'(h_sel)));
      if ($urandom_range(0, 3) == 0) count = count * $urandom_range(1, 2) +
                                             $urandom_range(0, count - 1);
      else count = count * $urandom_range(1, 2);
      case ($urandom_range(0, 3))
        0: rate = 0;
        1: rate = 100;
        2: rate = 400;
        default: rate = 1000;
      endcase
      push_random(count, rate);
      done_rand += count;
      drain();
    end
  endtask

  initial begin
    restart_frame();
    snd_idle = 33;
    rcv_idle = 51;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_random(6, 500);
    drain();

    set_frame(0, 0, 0);
    pix_q.push_back(pixel_t'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    pix_q.push_back(pixel_t'{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff});
    pix_q.push_back(pixel_t'{8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    pix_q.push_back(pixel_t'{8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00});
    pix_q.push_back(pixel_t'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7f});
    pix_q.push_back(pixel_t'{8'hff, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00});
    pix_q.push_back(pixel_t'{8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa});
    drain();

    set_frame(4, 3, 1);
    for (int i = 0; i < 12; i++) pix_q.push_back(rand_pixel((i == 5 || i == 10) ? 1000 : 0));
    drain();

    set_frame(1, 1, 0);
    @(posedge clk);
    hold_arm <= 1'b1;
    @(posedge clk);
    hold_arm <= 1'b0;
    @(negedge clk);
    push_random(40, 500);
    drain();

    random_frames(20);

    snd_idle = 51;
    rcv_idle = 33;
    set_frame(209, 1, 1);
    push_random(209, 20);
    drain();

    random_frames(40);

    snd_idle = 0;
    rcv_idle = 0;
    set_frame(8191, 1, 1);
    push_random(24, 500);
    drain();

    random_frames(60);

    if (err_count == 0) begin
      $display("tb_frame_diff_dirty_rect_core: clean");
    end else begin
      $display("tb_frame_diff_dirty_rect_core: errors");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("tb_frame_diff_dirty_rect_core: errors");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/frd_pkg.sv
hw/rtl/frame_diff_dirty_rect_core.sv
test/tb_frame_diff_dirty_rect_core.sv
